// ===== sv/grayscale_probe_rle_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Grayscale probe RLE decoder assertion macros
// Shared concurrent assertion forms used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_PROBE_RLE_DECODER_MACROS_SVH
`define GRAYSCALE_PROBE_RLE_DECODER_MACROS_SVH

// same-cycle implication
`define GPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpr same-cycle check failed");

// next-cycle implication
`define GPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpr next-cycle check failed");

`endif

// ===== sv/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Widths, constants and inter-module types of the grayscale probe RLE decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 64;
    localparam int SYNC_W  = 11;
    localparam int CNT_W   = 8;   // bits left in the current byte, up to 254
    localparam int FILL_W  = 6;   // bits held in the partial word, 0..63

    localparam logic [SYNC_W-1:0] SYNC_RESET = 11'd256;
    localparam logic [SYNC_W-1:0] ONES_MAX   = 11'd2047;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;

    // one bit pushed into the packer
    typedef struct packed {
        logic step;
        logic value;
        logic clear;
    } gpr_bit_t;

    // packer status back to the sequencer
    typedef struct packed {
        logic done;       // a full word leaves this cycle
        logic half;       // slice half of that word
        logic near_full;  // next pushed aligned bit completes a word
    } gpr_word_t;

endpackage

// ===== sv/gpr_if.sv =====
// ----------------------------------------------------------------------------
// gpr_if
// Valid/ready channel interfaces of the grayscale probe RLE decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpr_in_if;
    logic                         valid;
    logic                         ready;
    logic [gpr_pkg::BYTE_W-1:0]   compressed_byte;
    logic                         end_of_buffer;

    modport source (output valid, output compressed_byte, output end_of_buffer,
                    input ready);
    modport sink   (input valid, input compressed_byte, input end_of_buffer,
                    output ready);
endinterface

interface gpr_out_if;
    logic                         valid;
    logic                         ready;
    logic [gpr_pkg::WORD_W-1:0]   slice_word;
    logic                         upper_half;
    logic                         last_of_run;

    modport source (output valid, output slice_word, output upper_half,
                    output last_of_run, input ready);
    modport sink   (input valid, input slice_word, input upper_half,
                    input last_of_run, output ready);
endinterface

interface gpr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [gpr_pkg::SYNC_W-1:0]   sync_ones;

    modport source (output valid, output sync_ones, input ready);
    modport sink   (input valid, input sync_ones, output ready);
endinterface

// ===== sv/gpr_bit_packer.sv =====
// ----------------------------------------------------------------------------
// gpr_bit_packer
// One-bit-per-cycle sync detector and 64-bit word packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grayscale_probe_rle_decoder_macros.svh"

module gpr_bit_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gpr_pkg::SYNC_W-1:0]   sync_ones,
    input  gpr_pkg::gpr_bit_t            bit_in,
    output gpr_pkg::gpr_word_t           word_out,
    output logic [gpr_pkg::WORD_W-1:0]   word_data
);
    import gpr_pkg::*;

    logic [SYNC_W-1:0]   ones_run_reg, ones_run_next;
    logic                synced_reg, synced_next;
    logic [WORD_W-2:0]   pending_bits_reg, pending_bits_next;
    logic [FILL_W-1:0]   pending_count_reg, pending_count_next;
    logic                half_select_reg, half_select_next;
    logic                aligned;

    // bit is kept once synced, or when it is the zero that ends the sync run
    assign aligned = synced_reg || ((ones_run_reg >= sync_ones) && !bit_in.value);

    assign word_data = {pending_bits_reg, bit_in.value};

    always_comb
    begin
        ones_run_next      = ones_run_reg;
        synced_next        = synced_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        half_select_next   = half_select_reg;
        word_out.done      = 1'b0;
        word_out.half      = half_select_reg;
        word_out.near_full = (pending_count_reg == FILL_LAST);

        if (bit_in.clear)
        begin
            ones_run_next      = '0;
            synced_next        = 1'b0;
            pending_count_next = '0;
            half_select_next   = 1'b0;
        end
        else if (bit_in.step)
        begin
            if (!aligned)
            begin
                if (bit_in.value)
                begin
                    if (ones_run_reg != ONES_MAX)
                        ones_run_next = ones_run_reg + 1'b1;
                end
                else
                begin
                    ones_run_next = '0;
                end
            end
            else
            begin
                synced_next       = 1'b1;
                pending_bits_next = {pending_bits_reg[WORD_W-3:0], bit_in.value};
                if (pending_count_reg == FILL_LAST)
                begin
                    word_out.done      = 1'b1;
                    pending_count_next = '0;
                    half_select_next   = ~half_select_reg;
                end
                else
                begin
                    pending_count_next = pending_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_run_reg      <= '0;
            synced_reg        <= 1'b0;
            pending_count_reg <= '0;
            half_select_reg   <= 1'b0;
        end
        else
        begin
            ones_run_reg      <= ones_run_next;
            synced_reg        <= synced_next;
            pending_count_reg <= pending_count_next;
            half_select_reg   <= half_select_next;
        end
    end

    // payload, fully overwritten before any word leaves
    always_ff @(posedge clk)
    begin
        pending_bits_reg <= pending_bits_next;
    end

    `GPR_ASSERT_IMP(a_unsynced_empty, clk, rst_n, !synced_reg, pending_count_reg == '0)
    `GPR_ASSERT_NXT(a_half_flips, clk, rst_n, word_out.done, half_select_reg != $past(half_select_reg))
    `GPR_ASSERT_IMP(a_done_full, clk, rst_n, word_out.done, word_out.near_full && bit_in.step)

endmodule

// ===== sv/grayscale_probe_rle_decoder.sv =====
// A byte that expands to n bits (0..254) is busy until it finishes, and only
// then is a new byte taken; its final word enters the hold with its last bit
// and moves to the output register as the byte finishes, while an earlier
// word waits in the hold until the next word completes. The single bit-push
// packer handles one expanded bit per cycle; output stalls hold the sequencer.
// Reset (rst_n low, async): decoder state cleared, sync_ones back to 256.
// ----------------------------------------------------------------------------
// grayscale_probe_rle_decoder
// Expands run-length coded probe bytes, aligns on the sync run and emits
// 64-bit half-slice words through a one-word hold and an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grayscale_probe_rle_decoder_macros.svh"

module grayscale_probe_rle_decoder (
    input  logic        clk,
    input  logic        rst_n,
    gpr_cfg_if.sink     cfg,
    gpr_in_if.sink      din,
    gpr_out_if.source   dout
);
    import gpr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rep_reg, rep_next;
    logic [1:0]          pair_reg, pair_next;
    logic [5:0]          lit_reg, lit_next;
    logic                eob_reg, eob_next;
    logic [SYNC_W-1:0]   sync_ones_reg;

    logic [WORD_W-1:0]   hold_word_reg, hold_word_next;
    logic                hold_half_reg, hold_half_next;
    logic                hold_valid_reg, hold_valid_next;

    logic [WORD_W-1:0]   out_word_reg, out_word_next;
    logic                out_half_reg, out_half_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    logic                out_free;
    logic                finish;
    logic [CNT_W-1:0]    cnt_m1;
    gpr_bit_t            push;
    gpr_word_t           word;
    logic [WORD_W-1:0]   word_data;

    gpr_bit_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_ones (sync_ones_reg),
        .bit_in    (push),
        .word_out  (word),
        .word_data (word_data)
    );

    assign cfg.ready = 1'b1;
    assign din.ready = (state_reg == ST_IDLE);

    assign dout.valid       = out_valid_reg;
    assign dout.slice_word  = out_word_reg;
    assign dout.upper_half  = out_half_reg;
    assign dout.last_of_run = out_last_reg;

    assign out_free = !out_valid_reg || dout.ready;
    assign cnt_m1   = cnt_reg - 1'b1;

    // stall a bit that would complete a word while hold and output are both full
    assign push.step  = (state_reg == ST_RUN) && (cnt_reg != '0)
                        && !(word.near_full && hold_valid_reg && !out_free);
    assign push.value = rep_reg ? (cnt_reg[0] ? pair_reg[0] : pair_reg[1])
                                : lit_reg[cnt_m1[2:0]];
    assign finish     = (state_reg == ST_RUN) && (cnt_reg == '0)
                        && (!hold_valid_reg || out_free);
    assign push.clear = finish && eob_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rep_next        = rep_reg;
        pair_next       = pair_reg;
        lit_next        = lit_reg;
        eob_next        = eob_reg;
        hold_word_next  = hold_word_reg;
        hold_half_next  = hold_half_reg;
        hold_valid_next = hold_valid_reg;
        out_word_next   = out_word_reg;
        out_half_next   = out_half_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !dout.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    state_next = ST_RUN;
                    eob_next   = din.end_of_buffer;
                    rep_next   = din.compressed_byte[7];
                    lit_next   = din.compressed_byte[5:0];
                    if (din.compressed_byte[7])
                    begin
                        cnt_next = {din.compressed_byte[6:0], 1'b0};
                    end
                    else
                    begin
                        pair_next = din.compressed_byte[1:0];
                        if (din.compressed_byte[6])
                            cnt_next = 8'd6;
                        else if (din.compressed_byte[4])
                            cnt_next = 8'd4;
                        else if (din.compressed_byte[2])
                            cnt_next = 8'd2;
                        else
                            cnt_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (push.step)
                begin
                    cnt_next = cnt_m1;
                    if (word.done)
                    begin
                        // older word is not the last of this byte
                        if (hold_valid_reg)
                        begin
                            out_word_next  = hold_word_reg;
                            out_half_next  = hold_half_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_word_next  = word_data;
                        hold_half_next  = word.half;
                        hold_valid_next = 1'b1;
                    end
                end
                else if (finish)
                begin
                    if (hold_valid_reg)
                    begin
                        out_word_next  = hold_word_reg;
                        out_half_next  = hold_half_reg;
                        out_last_next  = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    if (eob_reg)
                        pair_next = 2'b00;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pair_reg       <= 2'b00;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sync_ones_reg  <= SYNC_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pair_reg       <= pair_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
                sync_ones_reg <= cfg.sync_ones;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg       <= rep_next;
        lit_reg       <= lit_next;
        eob_reg       <= eob_next;
        hold_word_reg <= hold_word_next;
        hold_half_reg <= hold_half_next;
        out_word_reg  <= out_word_next;
        out_half_reg  <= out_half_next;
        out_last_reg  <= out_last_next;
    end

    `GPR_ASSERT_IMP(a_hold_safe, clk, rst_n, word.done && hold_valid_reg, out_free)
    `GPR_ASSERT_NXT(a_last_flag, clk, rst_n, finish && hold_valid_reg, dout.valid && dout.last_of_run)
    `GPR_ASSERT_IMP(a_idle_empty, clk, rst_n, state_reg == ST_IDLE, !hold_valid_reg)

endmodule

// ===== tb/grayscale_probe_rle_decoder_check.sv =====
// ----------------------------------------------------------------------------
// grayscale_probe_rle_decoder_check
// Watches the config, byte and word channels, decodes every accepted byte
// on its own copy of the stream state and compares each word against the
// oldest word still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpr_tb_pkg;

    // control fields of a compressed byte
    localparam logic [7:0] REPEAT_FLAG = 8'h80;
    localparam logic [7:0] LIT6_FLAG   = 8'h40;
    localparam logic [7:0] LIT4_FLAG   = 8'h10;
    localparam logic [7:0] LIT2_FLAG   = 8'h04;
    localparam logic [7:0] PAIR_MASK   = 8'h03;
    localparam logic [7:0] COUNT_MASK  = 8'h7F;

endpackage

module grayscale_probe_rle_decoder_check (
    input  logic clk,
    input  logic rst_n,
    gpr_cfg_if   cfg_ch,
    gpr_in_if    in_ch,
    gpr_out_if   out_ch,
    output int   words_due,
    output int   fail_count
);

    import gpr_pkg::*;
    import gpr_tb_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              half;
        logic              last;
    } slice_word_t;

    logic [1:0]        pair_q;
    logic [SYNC_W-1:0] ones_q;
    logic [SYNC_W-1:0] sync_q;
    logic              aligned_q;
    logic [WORD_W-1:0] acc_q;
    int                fill_q;
    logic              half_q;
    int                byte_words;
    int                errors = 0;
    slice_word_t       words_ahead[$];

    task automatic clear_stream();
        pair_q    = '0;
        ones_q    = '0;
        aligned_q = 1'b0;
        acc_q     = '0;
        fill_q    = 0;
        half_q    = 1'b0;
    endtask

    task automatic push_stream_bit(input logic b);
        slice_word_t w;
        if (!aligned_q)
        begin
            if (ones_q >= sync_q && !b)
            begin
                aligned_q = 1'b1;
            end
            else
            begin
                if (!b)
                    ones_q = '0;
                else if (ones_q != ONES_MAX)
                    ones_q = ones_q + 1'b1;
                return;
            end
        end
        acc_q = {acc_q[WORD_W-2:0], b};
        fill_q++;
        if (fill_q == WORD_W)
        begin
            w.word = acc_q;
            w.half = half_q;
            w.last = 1'b0;
            words_ahead.push_back(w);
            byte_words++;
            half_q = ~half_q;
            acc_q  = '0;
            fill_q = 0;
        end
    endtask

    task automatic expand_byte(input logic [BYTE_W-1:0] b, input logic eob);
        int          width;
        int          reps;
        slice_word_t w;
        byte_words = 0;
        width      = 0;
        if ((b & REPEAT_FLAG) != 0)
        begin
            reps = int'(b & COUNT_MASK);
            for (int r = 0; r < reps; r++)
            begin
                push_stream_bit(pair_q[1]);
                push_stream_bit(pair_q[0]);
            end
        end
        else
        begin
            pair_q = 2'(b & PAIR_MASK);
            if ((b & LIT6_FLAG) != 0)
                width = 6;
            else if ((b & LIT4_FLAG) != 0)
                width = 4;
            else if ((b & LIT2_FLAG) != 0)
                width = 2;
            for (int i = width - 1; i >= 0; i--)
                push_stream_bit(b[i]);
        end
        // flag the final word this byte produced
        if (byte_words > 0)
        begin
            w = words_ahead.pop_back();
            w.last = 1'b1;
            words_ahead.push_back(w);
        end
        if (eob)
            clear_stream();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slice_word_t want;
        if (!rst_n)
        begin
            sync_q = SYNC_RESET;
            clear_stream();
            words_ahead.delete();
            words_due <= 0;
        end
        else
        begin
            // outputs first: a word can never come from a byte taken this edge
            if (out_ch.valid && out_ch.ready)
            begin
                if (words_ahead.size() == 0)
                begin
                    $error("slice word %h arrived with none due", out_ch.slice_word);
                    errors++;
                end
                else
                begin
                    want = words_ahead.pop_front();
                    if (out_ch.slice_word !== want.word)
                    begin
                        $error("slice_word: expected %h, got %h",
                               want.word, out_ch.slice_word);
                        errors++;
                    end
                    if (out_ch.upper_half !== want.half)
                    begin
                        $error("upper_half: expected %b, got %b",
                               want.half, out_ch.upper_half);
                        errors++;
                    end
                    if (out_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               want.last, out_ch.last_of_run);
                        errors++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sync_q = cfg_ch.sync_ones;
            if (in_ch.valid && in_ch.ready)
                expand_byte(in_ch.compressed_byte, in_ch.end_of_buffer);
            words_due <= words_ahead.size();
        end
        fail_count <= errors;
    end

endmodule

// ===== tb/grayscale_probe_rle_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// grayscale_probe_rle_decoder_tb
// Drives compressed bytes with random gaps and output stalls: a directed
// opener at the reset sync length, then sync-framed buffers with random
// content over several sync lengths; words are checked by the check module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grayscale_probe_rle_decoder_tb;

    import gpr_pkg::*;
    import gpr_tb_pkg::*;

    localparam int DRAIN_CYCLES    = 300;  // outlasts the longest byte
    localparam int ITEMS_PER_PHASE = 50;

    logic clk;
    logic rst_n;
    int   words_due;
    int   fail_count;
    int   sent = 0;
    int   calm_left = 0;

    gpr_cfg_if cfg_ch ();
    gpr_in_if  in_ch ();
    gpr_out_if out_ch ();

    grayscale_probe_rle_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .din   (in_ch),
        .dout  (out_ch)
    );

    grayscale_probe_rle_decoder_check slice_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_ch     (cfg_ch),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .words_due  (words_due),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
        int gap;
        gap = idle_len();
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.compressed_byte <= b;
        in_ch.end_of_buffer   <= eob;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    // drop valid, wait for all words due, then let any silent byte finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(input logic [SYNC_W-1:0] value);
        settle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.sync_ones <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // optional noise, a run of ones, a zero to align, then random content;
    // a broken preamble stops just short of the sync length
    task automatic send_buffer(input int sync_len, input bit broken);
        int                reps;
        int                n;
        int                body;
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        send_byte(PAIR_MASK, 1'b0);
        reps = (sync_len + 1) / 2;
        if (broken && reps > 0)
            reps--;
        while (reps > 0)
        begin
            n = (reps > 127) ? 127 : reps;
            send_byte(REPEAT_FLAG | 8'(n), 1'b0);
            reps -= n;
        end
        send_byte(LIT2_FLAG | 8'($urandom_range(0, 1)), 1'b0);
        body = $urandom_range(1, 14);
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                b = REPEAT_FLAG | 8'($urandom_range(0, 127));
            else
                b = 8'($urandom);
            send_byte(b, i == body - 1);
        end
    endtask

    initial
    begin
        int                goal;
        logic [SYNC_W-1:0] sync_plan [5];
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.compressed_byte <= '0;
        in_ch.end_of_buffer   <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.sync_ones      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opener at the reset sync length of 256
        send_byte(8'h00, 1'b0);  // pair 00, nothing out
        send_byte(8'h80, 1'b0);  // zero repeats
        send_byte(8'h03, 1'b0);  // pair 11
        send_byte(8'hFF, 1'b0);  // 254 ones
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);  // zero repeats keep pair 11
        send_byte(8'h04, 1'b0);  // 00: first zero aligns
        send_byte(8'h7F, 1'b0);  // six-bit literal, all ones
        send_byte(8'h40, 1'b0);  // six-bit literal, all zeros
        send_byte(8'h55, 1'b0);
        send_byte(8'h3F, 1'b0);  // four-bit literal, bit 5 ignored
        send_byte(8'h10, 1'b0);
        send_byte(8'h2A, 1'b0);  // no literal flag, pair 10
        send_byte(8'h07, 1'b0);  // two-bit literal
        send_byte(8'hFF, 1'b0);  // four words from one byte
        send_byte(8'h82, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);  // end of buffer drops the partial word
        send_byte(8'h03, 1'b0);  // one run short of sync
        send_byte(8'hFF, 1'b0);
        send_byte(8'h04, 1'b1);

        sync_plan = '{11'd0, 11'd1, 11'd2047, 11'($urandom_range(2, 1023)), 11'd1024};
        goal = sent;
        foreach (sync_plan[p])
        begin
            write_sync(sync_plan[p]);
            goal += ITEMS_PER_PHASE;
            while (sent < goal)
                send_buffer(sync_plan[p], $urandom_range(0, 4) == 0);
        end
        settle();

        if (fail_count == 0)
            $display("grayscale_probe_rle_decoder: match");
        else
            $display("grayscale_probe_rle_decoder: mismatch");
        $finish;
    end

    // word sink: random stalls with occasional long stretches of ready
    initial
    begin
        int hold;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 200)) @(posedge clk);
            end
            else
            begin
                hold = idle_len();
                if (hold > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("grayscale_probe_rle_decoder: mismatch");
        $finish;
    end

endmodule
